FILE: rtl/woy_pkg.sv
// Shared types, constants and arithmetic helpers for the week-of-year block.
// No dependencies; used by week_of_year_with_mode and woy_checker.
`default_nettype none

package woy_pkg;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned DOY_W  = 9;
  localparam int unsigned DOW_W  = 3;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned WEEK_W = 6;

  localparam logic [WEEK_W-1:0] WEEK_MAX = 6'd53;

  localparam logic [8:0] LEN_LEAP   = 9'd366;
  localparam logic [8:0] LEN_COMMON = 9'd365;

  // floor(y/25) = (y * 41944) >> 20, exact for y < 43690
  localparam logic [15:0] DIV25_MUL = 16'd41944;
  // floor(a/7) = (a * 1171) >> 13, exact for a < 1638
  localparam logic [10:0] DIV7_MUL  = 11'd1171;

  typedef struct packed {
    logic [9:0]        today;
    logic [3:0]        pos;
    logic [YEAR_W-1:0] year;
    logic [YEAR_W-1:0] year_m1;
    logic [9:0]        q25_y;
    logic [9:0]        q25_p;
    logic [9:0]        a;
    logic [6:0]        q7a;
    logic              first_wd;
    logic              roll;
  } s1_t;

  typedef struct packed {
    logic [9:0]        today;
    logic [3:0]        pos;
    logic [YEAR_W-1:0] year;
    logic [8:0]        max_day;
    logic [8:0]        prev_len;
    logic [3:0]        wk_start;   // two's complement, -2..7
    logic              first_wd;
    logic              roll;
  } s2_t;

  typedef struct packed {
    logic              to_next;
    logic              back;
    logic              week0;
    logic [6:0]        q7d1;
    logic [9:0]        today2;
    logic [9:0]        a2;
    logic [6:0]        q7a2;
    logic [YEAR_W-1:0] year;
    logic              first_wd;
  } s3_t;

  typedef struct packed {
    logic              to_next;
    logic              back;
    logic              week0;
    logic [6:0]        q7d1;
    logic [9:0]        d2;
    logic [YEAR_W-1:0] year;
  } s4_t;

  typedef struct packed {
    logic [YEAR_W-1:0] week_year;
    logic [WEEK_W-1:0] week_number;
  } res_t;

  function automatic logic [9:0] div25(input logic [YEAR_W-1:0] y);
    logic [29:0] p;
    p = {16'b0, y} * {14'b0, DIV25_MUL};
    return p[29:20];
  endfunction

  function automatic logic [6:0] div7(input logic [9:0] a);
    logic [20:0] p;
    p = {11'b0, a} * {10'b0, DIV7_MUL};
    return p[19:13];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [9:0] q25);
    logic [YEAR_W-1:0] m25;
    logic              div_by_25;
    m25       = YEAR_W'({4'b0, q25} * 14'd25);
    div_by_25 = (y == m25);
    // by 100 means by 4 and 25, by 400 means by 16 and 25
    return (y[1:0] == 2'b00) && (!div_by_25 || (y[3:0] == 4'b0000));
  endfunction

  // first day of week one from a = today + 8 - pos and its quotient by 7
  function automatic logic [3:0] week_start(input logic [9:0] a, input logic [6:0] q,
                                            input logic first_wd);
    logic [9:0] r;
    logic [3:0] s;
    r = a - 10'({3'b0, q} * 10'd7);
    s = {1'b0, r[2:0]};
    if (s == 4'd0) begin
      s = 4'd7;
    end
    if (!first_wd && (s >= 4'd5)) begin
      s = s - 4'd7;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/week_of_year_with_mode.sv
// Week-of-year calculator with selectable week rules, five-stage pipeline.
// Depends on woy_pkg (types, constants and reciprocal helpers).
//
// Usage:
//   in channel  : one date per item; tdata holds day_of_year, day_of_week and
//                 calendar_year, tuser holds the three mode bits
//   out channel : one result per item, week_number and week_year in tdata
//   stages      : five register stages, the first loaded at the accepting
//                 edge; out_tvalid rises when the last stage is loaded and the
//                 result can be taken at an edge when the sink is ready
//   throughput  : one item per cycle while the output is not stalled; each
//                 stage holds one item and does a few small constant
//                 multiplies (reciprocal divides by 25 and by 7, or the
//                 matching back-multiplies) plus a compare or select
//   stall       : each stage moves when the one after it is empty or moving,
//                 so bubbles close up and in_tready stays high while any
//                 stage is free; a result waiting at the output holds its
//                 tdata until out_tready
//   reset       : rst_n low clears all stage valid bits and holds in_tready
//                 low; nothing is in flight afterwards and the block accepts
//                 an item as soon as rst_n is high
`default_nettype none

module week_of_year_with_mode (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [8:0] day_of_year, [11:9] day_of_week, [25:12] calendar_year, [31:26] zero
  input  wire  [woy_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] sunday_start, [1] first_weekday_rule, [2] roll_edge_weeks
  input  wire  [woy_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [5:0] week_number, [19:6] week_year, [23:20] zero
  output logic [woy_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  woy_pkg::s1_t  s1_r, s1_nxt;
  woy_pkg::s2_t  s2_r, s2_nxt;
  woy_pkg::s3_t  s3_r, s3_nxt;
  woy_pkg::s4_t  s4_r, s4_nxt;
  woy_pkg::res_t res_r, res_nxt;

  // per-stage advance: a stage loads when it is empty or its content moves on
  assign adv5      = !v5_r || out_tready;
  assign adv4      = !v4_r || adv5;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = rst_n && adv1;

  // stage 1: decode, position in week, reciprocal products
  always_comb begin
    logic [8:0]  doy;
    logic [2:0]  wd;
    logic [13:0] yr;
    logic        sun;
    doy = in_tdata[8:0];
    wd  = in_tdata[11:9];
    yr  = in_tdata[25:12];
    sun = in_tuser[0];
    s1_nxt.today = {1'b0, doy} + 10'd1;
    if (sun) begin
      s1_nxt.pos = {1'b0, wd} + 4'd1;
    end else if (wd == 3'd0) begin
      s1_nxt.pos = 4'd7;
    end else begin
      s1_nxt.pos = {1'b0, wd};
    end
    s1_nxt.year     = yr;
    s1_nxt.year_m1  = yr - 14'd1;
    s1_nxt.q25_y    = woy_pkg::div25(yr);
    s1_nxt.q25_p    = woy_pkg::div25(yr - 14'd1);
    s1_nxt.a        = s1_nxt.today + 10'd8 - {6'b0, s1_nxt.pos};
    s1_nxt.q7a      = woy_pkg::div7(s1_nxt.a);
    s1_nxt.first_wd = in_tuser[1];
    s1_nxt.roll     = in_tuser[2];
  end

  // stage 2: leap years, year lengths, start of week one
  always_comb begin
    s2_nxt.today    = s1_r.today;
    s2_nxt.pos      = s1_r.pos;
    s2_nxt.year     = s1_r.year;
    s2_nxt.max_day  = woy_pkg::is_leap(s1_r.year, s1_r.q25_y) ?
                      woy_pkg::LEN_LEAP : woy_pkg::LEN_COMMON;
    s2_nxt.prev_len = woy_pkg::is_leap(s1_r.year_m1, s1_r.q25_p) ?
                      woy_pkg::LEN_LEAP : woy_pkg::LEN_COMMON;
    s2_nxt.wk_start = woy_pkg::week_start(s1_r.a, s1_r.q7a, s1_r.first_wd);
    s2_nxt.first_wd = s1_r.first_wd;
    s2_nxt.roll     = s1_r.roll;
  end

  // stage 3: edge decisions, plain week quotient, rolled-back day
  always_comb begin
    logic signed [11:0] today_sx;
    logic signed [11:0] start_sx;
    logic signed [11:0] tail;
    logic signed [11:0] d1;
    logic               before_start;
    logic               late;
    today_sx     = $signed({2'b00, s2_r.today});
    start_sx     = $signed({{8{s2_r.wk_start[3]}}, s2_r.wk_start});
    before_start = (today_sx < start_sx);
    late         = (s2_r.today > ({1'b0, s2_r.max_day} - 10'd3));
    // days of this week that fall in the current year
    tail         = $signed({3'b000, s2_r.max_day}) - today_sx + $signed({8'b0, s2_r.pos});
    d1           = today_sx - start_sx;
    s3_nxt.to_next  = s2_r.roll && !s2_r.first_wd && late && (tail <= 12'sd3);
    s3_nxt.back     = s2_r.roll && before_start;
    s3_nxt.week0    = before_start;
    s3_nxt.q7d1     = woy_pkg::div7(d1[9:0]);
    s3_nxt.today2   = s2_r.today + {1'b0, s2_r.prev_len};
    s3_nxt.a2       = s3_nxt.today2 + 10'd8 - {6'b0, s2_r.pos};
    s3_nxt.q7a2     = woy_pkg::div7(s3_nxt.a2);
    s3_nxt.year     = s2_r.year;
    s3_nxt.first_wd = s2_r.first_wd;
  end

  // stage 4: week-one start within the previous year
  always_comb begin
    logic [3:0]         s2v;
    logic signed [11:0] d2;
    s2v            = woy_pkg::week_start(s3_r.a2, s3_r.q7a2, s3_r.first_wd);
    d2             = $signed({2'b00, s3_r.today2}) - $signed({{8{s2v[3]}}, s2v});
    s4_nxt.to_next = s3_r.to_next;
    s4_nxt.back    = s3_r.back;
    s4_nxt.week0   = s3_r.week0;
    s4_nxt.q7d1    = s3_r.q7d1;
    s4_nxt.d2      = d2[9:0];
    s4_nxt.year    = s3_r.year;
  end

  // stage 5: final select and saturation
  always_comb begin
    logic [7:0] wk;
    logic [6:0] q7d2;
    q7d2 = woy_pkg::div7(s4_r.d2);
    res_nxt.week_year = s4_r.year;
    if (s4_r.to_next) begin
      wk                = 8'd1;
      res_nxt.week_year = s4_r.year + 14'd1;
    end else if (s4_r.back) begin
      wk                = {1'b0, q7d2} + 8'd1;
      res_nxt.week_year = s4_r.year - 14'd1;
    end else if (s4_r.week0) begin
      wk = 8'd0;
    end else begin
      wk = {1'b0, s4_r.q7d1} + 8'd1;
    end
    if (wk > {2'b00, woy_pkg::WEEK_MAX}) begin
      res_nxt.week_number = woy_pkg::WEEK_MAX;
    end else begin
      res_nxt.week_number = wk[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      if (adv5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
    if (adv2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (adv3 && v2_r) begin
      s3_r <= s3_nxt;
    end
    if (adv4 && v3_r) begin
      s4_r <= s4_nxt;
    end
    if (adv5 && v4_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {4'b0000, res_r.week_year, res_r.week_number};

endmodule

`default_nettype wire

FILE: rtl/woy_checker.sv
// Port-level checks for week_of_year_with_mode, attached by bind.
// Depends on woy_pkg for channel widths.
`default_nettype none

module woy_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [woy_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // nothing in flight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a ready sink means every stage moves, so the input side is never blocked
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while sink ready");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_week_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] <= 6'd53))
    else $error("week number above 53");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:20] == 4'b0000))
    else $error("tdata padding not zero");

endmodule

bind week_of_year_with_mode woy_checker u_woy_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: verif/woy_checker.sv
// Checker for week_of_year_with_mode: watches both stream channels, predicts
// the week number and week year of every accepted date and compares results.
// Depends on woy_pkg for the result struct and the port widths.
`default_nettype none

module woy_scoreboard (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  // [8:0] day_of_year, [11:9] day_of_week, [25:12] calendar_year, [31:26] zero
  input  wire  [woy_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] sunday_start, [1] first_weekday_rule, [2] roll_edge_weeks
  input  wire  [woy_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  // [5:0] week_number, [19:6] week_year, [23:20] zero
  input  wire  [woy_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int unsigned                      fail_count,
  output int unsigned                      waiting
);

  woy_pkg::res_t expected_weeks[$];

  function automatic int year_days(input logic [woy_pkg::YEAR_W-1:0] y);
    int yi;
    yi = int'(y);
    if (((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0)) begin
      return 366;
    end
    return 365;
  endfunction

  // 1-based first day of week one, which can be zero or below under the four-day rule
  function automatic int first_week_day(input int today, input int pos, input logic fwd);
    int s;
    s = (today + 8 - pos) % 7;
    if (s == 0) begin
      s = 7;
    end
    if (!fwd && (s >= 5)) begin
      s = s - 7;
    end
    return s;
  endfunction

  function automatic woy_pkg::res_t calc_week(input logic [woy_pkg::DOY_W-1:0] doy,
                                              input logic [woy_pkg::DOW_W-1:0] dow,
                                              input logic [woy_pkg::YEAR_W-1:0] year,
                                              input logic [woy_pkg::IN_TUSER_W-1:0] mode);
    int today, pos, max_day, first_day, s, week;
    logic sun, fwd, roll, to_next;
    logic [woy_pkg::YEAR_W-1:0] wyear;
    woy_pkg::res_t r;
    sun     = mode[0];
    fwd     = mode[1];
    roll    = mode[2];
    today   = int'(doy) + 1;
    // weekday seven lands on position eight with a sunday start
    if (sun) begin
      pos = int'(dow) + 1;
    end else begin
      pos = (dow == '0) ? 7 : int'(dow);
    end
    max_day = year_days(year);
    wyear   = year;
    to_next = 1'b0;
    if (roll && !fwd && (today > max_day - 3)) begin
      first_day = today - pos + 1;
      if (max_day - first_day + 1 <= 3) begin
        to_next = 1'b1;
      end
    end
    if (to_next) begin
      wyear = year + 1'b1;
      week  = 1;
    end else begin
      s = first_week_day(today, pos, fwd);
      if ((today < s) && roll) begin
        wyear = year - 1'b1;
        today = today + year_days(wyear);
        s     = first_week_day(today, pos, fwd);
        week  = (today - s) / 7 + 1;
      end else if (today < s) begin
        week = 0;
      end else begin
        week = (today - s) / 7 + 1;
      end
    end
    if (week > 53) begin
      week = 53;
    end
    if (week < 0) begin
      week = 0;
    end
    r.week_number = week[woy_pkg::WEEK_W-1:0];
    r.week_year   = wyear;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    woy_pkg::res_t want;
    logic [woy_pkg::WEEK_W-1:0] got_week;
    logic [woy_pkg::YEAR_W-1:0] got_year;
    got_week = out_tdata[5:0];
    got_year = out_tdata[19:6];
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      // results first so an item accepted this cycle is never matched early
      if (out_tvalid && out_tready) begin
        if (expected_weeks.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual week %0d year %0d",
                   $time, got_week, got_year);
        end else begin
          want = expected_weeks.pop_front();
          if (got_week !== want.week_number) begin
            fail_count++;
            $display("%0t: week_number mismatch, expected %0d, actual %0d",
                     $time, want.week_number, got_week);
          end
          if (got_year !== want.week_year) begin
            fail_count++;
            $display("%0t: week_year mismatch, expected %0d, actual %0d",
                     $time, want.week_year, got_year);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_weeks.push_back(calc_week(in_tdata[8:0], in_tdata[11:9],
                                           in_tdata[25:12], in_tuser));
      end
    end
    waiting <= unsigned'(expected_weeks.size());
  end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Testbench top for week_of_year_with_mode: drives directed and random dates
// under all eight week modes with random idling on both channels.
// Depends on woy_pkg, the block itself and woy_scoreboard.
`default_nettype none

module tb_top;

  localparam int RAND_ITEMS = 1600;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [woy_pkg::IN_TDATA_W-1:0]   in_tdata   = '0;
  logic [woy_pkg::IN_TUSER_W-1:0]   in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [woy_pkg::OUT_TDATA_W-1:0]  out_tdata;
  int unsigned                      fail_count;
  int unsigned                      waiting;
  bit                               send_burst = 1'b0;
  bit                               sink_burst = 1'b0;
  int                               special_years[8] = '{1, 9999, 1900, 2000, 2004, 2100,
                                                         2400, 1600};

  always #1 clk = ~clk;

  week_of_year_with_mode uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  woy_scoreboard chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  // mode bits: [0] sunday start, [1] first weekday rule, [2] roll edge weeks
  task automatic send_date(input int doy, input int dow, input int year, input int mode);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, year[13:0], dow[2:0], doy[8:0]};
    in_tuser  <= mode[2:0];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int doy, dow, year, mode, ylen, y1, jan1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // every mode on the first and last day of a year starting on friday
    for (int m = 0; m < 8; m++) begin
      send_date(0, 5, 2021, m);
    end
    for (int m = 0; m < 8; m++) begin
      send_date(364, 5, 2021, m);
    end
    send_date(364, 1, 16383, 3'b100);  // year wraps forward to zero
    send_date(0, 6, 0, 3'b111);        // year zero rolls back to the top year
    send_date(0, 3, 2001, 3'b100);     // stays in week one of its own year
    send_date(365, 7, 2000, 3'b011);   // weekday seven, sunday start
    send_date(200, 7, 1900, 3'b010);   // weekday seven, monday start
    send_date(511, 0, 9999, 3'b000);   // week count saturates
    send_date(365, 6, 1, 3'b011);
    send_date(511, 7, 16383, 3'b111);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 50 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
      end
      mode = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) begin
        // raw fields, dates need not be valid
        doy  = $urandom_range(0, 511);
        dow  = $urandom_range(0, 7);
        year = $urandom_range(0, 16383);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          year = special_years[$urandom_range(0, 7)];
        end else begin
          year = $urandom_range(1, 9999);
        end
        ylen = (((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0)) ? 366 : 365;
        case ($urandom_range(0, 3))
          0: doy = $urandom_range(0, 7);
          1: doy = $urandom_range(ylen - 8, ylen - 1);
          default: doy = $urandom_range(0, ylen - 1);
        endcase
        // weekday of january first, sunday as zero
        y1   = year - 1;
        jan1 = (1 + 5 * (y1 % 4) + 4 * (y1 % 100) + 6 * (y1 % 400)) % 7;
        dow  = (jan1 + doy) % 7;
      end
      send_date(doy, dow, year, mode);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (waiting != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : sink
    int hold, got;
    got = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got % 64 == 0) begin
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      // one long back-pressure stretch so the pipeline fills and stalls input
      if (got == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      hold = sink_burst ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/woy_pkg.sv
rtl/week_of_year_with_mode.sv
rtl/woy_checker.sv
verif/woy_checker.sv
verif/tb_top.sv
